// ===== src/bal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bal_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded array list.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream items
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 3;
    localparam int NCOUNT_W = 4;
    localparam int REMOVED_W = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT  = 3'd0,
        OP_APPEND     = 3'd1,
        OP_DEL_FRONT  = 3'd2,
        OP_DEL_BACK   = 3'd3,
        OP_DEL_FIRST  = 3'd4,
        OP_DEL_ALL    = 3'd5,
        OP_READ       = 3'd6,
        OP_UNUSED     = 3'd7
    } op_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        UOP_NOP      = 4'd0,
        UOP_START    = 4'd1,
        UOP_DISPATCH = 4'd2,
        UOP_SHIFT_RD = 4'd3,
        UOP_SHIFT_WR = 4'd4,
        UOP_HEAD_WR  = 4'd5,
        UOP_CMP_RD   = 4'd6,
        UOP_CMP_WR   = 4'd7,
        UOP_READ_RD  = 4'd8,
        UOP_READ_CAP = 4'd9
    } uop_t;

    typedef struct packed {
        uop_t uop;
        logic emit;
    } bal_cmd_t;

    typedef struct packed {
        op_code_t op;
        logic     full;
        logic     empty;
        logic     in_range;
        logic     count_zero;
        logic     shift_last;
        logic     cmp_last;
        logic     out_free;
    } bal_stat_t;

endpackage
`default_nettype wire

// ===== src/bounded_array_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list
// Fixed-capacity ordered list of signed 32-bit values with insert at front,
// append, remove front/back, remove first or all matches, and indexed read.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  ------------------------------------------
//  s_*      in   s_tvalid/s_tready  op, value, position   (one request item)
//  m_*      out  m_tvalid/m_tready  status, new_count, read_value, removed
//
//  Sequencing: one request at a time. Append, remove back, unused op and
//  any rejected request go from dispatch straight to the result; read
//  reads the store once and captures the entry; insert front shifts every
//  entry up one place before writing the head, and the removals that match
//  or drop the head walk every entry. Each entry moved costs a read and a
//  write on the store. s_tready is high only while the sequencer is idle.
//  Reset clears the count and the output valid; the store keeps no reset.
//  A stalled result holds in the output register; the next request is
//  taken meanwhile and its result waits until the register frees.
//
module bounded_array_list (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata: [2:0] op, [34:3] value, [37:35] position, [39:38] zero
    input  wire  [39:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata: [2:0] status, [6:3] new_count, [38:7] read_value,
    //          [42:39] removed, [47:43] zero
    output logic [47:0] m_tdata
);
    import bal_pkg::*;

    bal_cmd_t  cmd;
    bal_stat_t stat;

    // Sequencer: request acceptance, store walks, result hand-off
    bal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, count, pointers and the output register
    bal_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== src/bal_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bal_datapath
// Entry store, count, walk pointers, working result and output register.
// ----------------------------------------------------------------------------
module bal_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  bal_pkg::bal_cmd_t            cmd,
    output bal_pkg::bal_stat_t           stat,
    input  wire [bal_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [bal_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bal_pkg::*;

    logic [VALUE_W-1:0] mem [CAPACITY];

    op_code_t            op_reg;
    logic [VALUE_W-1:0]  key_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    ri_reg, ri_next;
    logic [CNT_W-1:0]    wi_reg, wi_next;
    logic                found_reg, found_next;
    status_t             status_reg, status_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic [VALUE_W-1:0]  rd_value_reg, rd_value_next;
    logic [VALUE_W-1:0]  rdata_reg;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [NCOUNT_W-1:0] out_count_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [REMOVED_W-1:0] out_removed_reg;

    logic                we, re;
    logic [IDX_W-1:0]    waddr, raddr;
    logic [VALUE_W-1:0]  wdata;
    logic                full, empty, in_range, drop;
    logic [CNT_W-1:0]    count_m1;

    assign count_m1 = count_reg - CNT_W'(1);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign in_range = (32'(pos_reg) < 32'(count_reg));

    assign drop = ((op_reg == OP_DEL_FRONT) && (ri_reg == '0))
               || ((op_reg == OP_DEL_FIRST) && (rdata_reg == key_reg) && !found_reg)
               || ((op_reg == OP_DEL_ALL) && (rdata_reg == key_reg));

    always_comb
    begin
        stat.op         = op_reg;
        stat.full       = full;
        stat.empty      = empty;
        stat.in_range   = in_range;
        stat.count_zero = empty;
        stat.shift_last = (ri_reg == '0);
        stat.cmp_last   = (CNT_W'(ri_reg) == count_m1);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        count_next    = count_reg;
        ri_next       = ri_reg;
        wi_next       = wi_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        rd_value_next = rd_value_reg;
        we    = 1'b0;
        re    = 1'b0;
        waddr = '0;
        raddr = '0;
        wdata = key_reg;
        unique case (cmd.uop)
            UOP_NOP:
            begin
            end
            UOP_START:
            begin
                status_next   = ST_OK;
                removed_next  = '0;
                rd_value_next = '0;
                found_next    = 1'b0;
                wi_next       = '0;
                ri_next       = '0;
            end
            UOP_DISPATCH:
            begin
                unique case (op_reg)
                    OP_INS_FRONT:
                    begin
                        if (full)
                            status_next = ST_FULL;
                        else
                            ri_next = IDX_W'(count_m1);
                    end
                    OP_APPEND:
                    begin
                        if (full)
                            status_next = ST_FULL;
                        else
                        begin
                            we         = 1'b1;
                            waddr      = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_DEL_BACK:
                    begin
                        if (empty)
                            status_next = ST_EMPTY;
                        else
                        begin
                            count_next   = count_m1;
                            removed_next = CNT_W'(1);
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_FIRST, OP_DEL_ALL:
                    begin
                        if (empty)
                            status_next = ST_EMPTY;
                    end
                    OP_READ:
                    begin
                        if (!in_range)
                            status_next = ST_RANGE;
                    end
                    OP_UNUSED:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            UOP_SHIFT_RD:
            begin
                re    = 1'b1;
                raddr = ri_reg;
            end
            UOP_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = ri_reg + IDX_W'(1);
                wdata = rdata_reg;
                if (ri_reg != '0)
                    ri_next = ri_reg - IDX_W'(1);
            end
            UOP_HEAD_WR:
            begin
                we         = 1'b1;
                waddr      = '0;
                count_next = count_reg + CNT_W'(1);
            end
            UOP_CMP_RD:
            begin
                re    = 1'b1;
                raddr = ri_reg;
            end
            UOP_CMP_WR:
            begin
                if (drop)
                    found_next = 1'b1;
                else
                begin
                    we      = 1'b1;
                    waddr   = wi_reg[IDX_W-1:0];
                    wdata   = rdata_reg;
                    wi_next = wi_reg + CNT_W'(1);
                end
                // Last entry: commit the compacted count
                if (CNT_W'(ri_reg) == count_m1)
                begin
                    count_next   = wi_next;
                    removed_next = count_reg - wi_next;
                    if (count_reg == wi_next)
                        status_next = ST_NOTFOUND;
                end
                else
                    ri_next = ri_reg + IDX_W'(1);
            end
            UOP_READ_RD:
            begin
                re    = 1'b1;
                raddr = IDX_W'(pos_reg);
            end
            UOP_READ_CAP:
            begin
                rd_value_next = rdata_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Request and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_OK;
            op_reg     <= OP_UNUSED;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            if (cmd.uop == UOP_START)
                op_reg <= op_code_t'(s_tdata[OP_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        ri_reg       <= ri_next;
        wi_reg       <= wi_next;
        found_reg    <= found_next;
        removed_reg  <= removed_next;
        rd_value_reg <= rd_value_next;
        if (cmd.uop == UOP_START)
        begin
            key_reg <= s_tdata[OP_W +: VALUE_W];
            pos_reg <= s_tdata[OP_W + VALUE_W +: POS_W];
        end
    end

    // Output register
    assign out_valid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg  <= status_reg;
            out_count_reg   <= NCOUNT_W'(count_reg);
            out_value_reg   <= rd_value_reg;
            out_removed_reg <= REMOVED_W'(removed_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_removed_reg, out_value_reg, out_count_reg, out_status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (status_reg == ST_FULL) |-> full)
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (status_reg == ST_EMPTY) |-> empty)
        else $error("empty status with entries present");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (status_reg != ST_OK) |-> (rd_value_reg == '0) && !we)
        else $error("failed operation carries read data or writes");

endmodule
`default_nettype wire

// ===== src/bal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bal_ctrl
// Sequencer: accepts a request, walks the store and hands off the result.
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  bal_pkg::bal_stat_t stat,
    output bal_pkg::bal_cmd_t  cmd
);
    import bal_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_SHIFT_RD = 10'b00_0000_0100,
        S_SHIFT_WR = 10'b00_0000_1000,
        S_HEAD_WR  = 10'b00_0001_0000,
        S_CMP_RD   = 10'b00_0010_0000,
        S_CMP_WR   = 10'b00_0100_0000,
        S_READ_RD  = 10'b00_1000_0000,
        S_READ_CAP = 10'b01_0000_0000,
        S_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.uop    = UOP_NOP;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.uop    = UOP_START;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.uop    = UOP_DISPATCH;
                state_next = S_FINISH;
                unique case (stat.op)
                    OP_INS_FRONT:
                        if (!stat.full)
                            state_next = stat.count_zero ? S_HEAD_WR : S_SHIFT_RD;
                    OP_DEL_FRONT, OP_DEL_FIRST, OP_DEL_ALL:
                        if (!stat.empty)
                            state_next = S_CMP_RD;
                    OP_READ:
                        if (stat.in_range)
                            state_next = S_READ_RD;
                    OP_APPEND, OP_DEL_BACK, OP_UNUSED:
                        state_next = S_FINISH;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_SHIFT_RD:
            begin
                cmd.uop    = UOP_SHIFT_RD;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.uop    = UOP_SHIFT_WR;
                state_next = stat.shift_last ? S_HEAD_WR : S_SHIFT_RD;
            end
            S_HEAD_WR:
            begin
                cmd.uop    = UOP_HEAD_WR;
                state_next = S_FINISH;
            end
            S_CMP_RD:
            begin
                cmd.uop    = UOP_CMP_RD;
                state_next = S_CMP_WR;
            end
            S_CMP_WR:
            begin
                cmd.uop    = UOP_CMP_WR;
                state_next = stat.cmp_last ? S_FINISH : S_CMP_RD;
            end
            S_READ_RD:
            begin
                cmd.uop    = UOP_READ_RD;
                state_next = S_READ_CAP;
            end
            S_READ_CAP:
            begin
                cmd.uop    = UOP_READ_CAP;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("result handed off without returning to idle");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

endmodule
`default_nettype wire

// ===== tb/sv/tb_bounded_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list
// Self-checking bench for the bounded array list. A short table of directed
// requests covers the empty and full corners, the extreme values and every
// operation; random requests follow in fill, drain and mixed phases drawn
// from small key pools so that matches are common. Each result item is checked
// against the table's typed result where set, else a software list copy.
// ----------------------------------------------------------------------------
module tb_bounded_array_list;

    import bal_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_AFTER   = 120;    // items accepted before the long stall
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        op_code_t           op;
        logic signed [31:0] value;
        logic [2:0]         position;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         new_count;
        logic signed [31:0] read_value;
        logic [3:0]         removed;
    } result_t;

    // One directed row: the request, and a typed result where fixed is set.
    typedef struct packed {
        request_t req;
        logic     fixed;
        result_t  res;
    } plan_row_t;

    localparam int PLAN_LEN = 25;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // empty list: every removal and every read is refused
        '{'{OP_READ,      32'sh00000000, 3'd0}, 1'b1, '{ST_RANGE, 4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_FRONT, 32'sh00000000, 3'd0}, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_BACK,  32'sh00000000, 3'd0}, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_FIRST, 32'sh00000000, 3'd0}, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_ALL,   32'sh00000000, 3'd0}, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 4'd0}},
        // unused code with every field bit set is ignored
        '{'{OP_UNUSED,    32'shFFFFFFFF, 3'd7}, 1'b1, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        // fill to capacity with the extreme values
        '{'{OP_APPEND,    32'sh7FFFFFFF, 3'd7}, 1'b1, '{ST_OK,    4'd1, 32'sd0, 4'd0}},
        '{'{OP_INS_FRONT, 32'sh80000000, 3'd0}, 1'b1, '{ST_OK,    4'd2, 32'sd0, 4'd0}},
        '{'{OP_APPEND,    32'shFFFFFFFF, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_APPEND,    32'sh00000000, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_INS_FRONT, 32'sh00000005, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_APPEND,    32'sh00000005, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_APPEND,    32'sh55555555, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_APPEND,    32'shAAAAAAAA, 3'd0}, 1'b1, '{ST_OK,    4'd8, 32'sd0, 4'd0}},
        // full list refuses both inserts
        '{'{OP_APPEND,    32'sh00000001, 3'd0}, 1'b1, '{ST_FULL,  4'd8, 32'sd0, 4'd0}},
        '{'{OP_INS_FRONT, 32'sh00000001, 3'd0}, 1'b1, '{ST_FULL,  4'd8, 32'sd0, 4'd0}},
        // reads at both ends of a full list
        '{'{OP_READ,      32'sh00000000, 3'd7}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_READ,      32'sh00000000, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        // key missing, then first match at the head, then the remaining match
        '{'{OP_DEL_FIRST, 32'sh00003039, 3'd0}, 1'b1, '{ST_NOTFOUND, 4'd8, 32'sd0, 4'd0}},
        '{'{OP_DEL_FIRST, 32'sh00000005, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_ALL,   32'sh00000005, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_ALL,   32'sh00000063, 3'd0}, 1'b1, '{ST_NOTFOUND, 4'd6, 32'sd0, 4'd0}},
        '{'{OP_DEL_FRONT, 32'sh00000000, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        '{'{OP_DEL_BACK,  32'sh00000000, 3'd0}, 1'b0, '{ST_OK,    4'd0, 32'sd0, 4'd0}},
        // read past the count on a partly filled list
        '{'{OP_READ,      32'sh00000000, 3'd7}, 1'b1, '{ST_RANGE, 4'd4, 32'sd0, 4'd0}}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Set during the long receiver stall so the block backs up to its input.
    logic        sink_hold = 1'b0;

    // Software copy of the list, advanced once per accepted request.
    logic [31:0] list_mem [CAPACITY];
    int          list_len = 0;

    result_t     pending_results [$];
    int          accepted_items = 0;
    int          mismatch_count = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    bounded_array_list DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one request to the list copy and return the result it produces.
    function automatic result_t list_apply(request_t r);
        result_t res;
        int      i;
        int      w;
        res.status     = ST_OK;
        res.read_value = '0;
        res.removed    = '0;
        case (r.op)
            OP_INS_FRONT, OP_APPEND:
            begin
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else if (r.op == OP_APPEND)
                begin
                    list_mem[list_len] = r.value;
                    list_len++;
                end
                else
                begin
                    for (i = list_len; i > 0; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[0] = r.value;
                    list_len++;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_FIRST, OP_DEL_ALL:
            begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else if (r.op == OP_DEL_BACK)
                begin
                    list_len--;
                    res.removed = 4'd1;
                end
                else if (r.op == OP_DEL_ALL)
                begin
                    // compact the survivors toward the head
                    w = 0;
                    for (i = 0; i < list_len; i++)
                        if (list_mem[i] != r.value)
                        begin
                            list_mem[w] = list_mem[i];
                            w++;
                        end
                    res.removed = 4'(list_len - w);
                    list_len    = w;
                    if (res.removed == 0)
                        res.status = ST_NOTFOUND;
                end
                else
                begin
                    // head removal or first match: close the gap at index i
                    i = 0;
                    if (r.op == OP_DEL_FIRST)
                        while (i < list_len && list_mem[i] != r.value)
                            i++;
                    if (i < list_len)
                    begin
                        while (i + 1 < list_len)
                        begin
                            list_mem[i] = list_mem[i+1];
                            i++;
                        end
                        list_len--;
                        res.removed = 4'd1;
                    end
                    else
                        res.status = ST_NOTFOUND;
                end
            end
            OP_READ:
            begin
                if (int'(r.position) < list_len)
                    res.read_value = list_mem[r.position];
                else
                    res.status = ST_RANGE;
            end
            default: ;
        endcase
        res.new_count = 4'(list_len);
        return res;
    endfunction

    // Idle cycles before the next item; calm stretches draw no idling at all.
    function automatic int draw_idle(inout bit calm);
        if ($urandom_range(0, 19) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Offer one request, hold it until accepted, then log what it must produce.
    task automatic offer_request(request_t r, logic fixed, result_t typed);
        int      idle;
        result_t predicted;
        idle = draw_idle(send_calm);
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tdata  <= {2'b00, r.position, r.value, r.op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // keep the list copy in step even where the table types the answer
        predicted = list_apply(r);
        pending_results.push_back(fixed ? typed : predicted);
        accepted_items++;
    endtask

    // Stimulus: reset, directed table, random phases, then drain and verdict.
    initial
    begin : stimulus
        request_t    req;
        logic [31:0] key_pool [4];
        int          pool_size;
        int          phase;
        int          roll;
        int          k;
        int          n;
        pool_size = 1;
        phase     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < PLAN_LEN; n++)
            offer_request(PLAN[n].req, PLAN[n].fixed, PLAN[n].res);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // new phase: pick fill, drain or mixed, and a fresh small key pool
            if (n % 40 == 0)
            begin
                phase     = $urandom_range(0, 2);
                pool_size = $urandom_range(1, 4);
                for (k = 0; k < 4; k++)
                    case ($urandom_range(0, 5))
                        0:       key_pool[k] = 32'h7FFFFFFF;
                        1:       key_pool[k] = 32'h80000000;
                        2:       key_pool[k] = 32'h00000000;
                        3:       key_pool[k] = 32'hFFFFFFFF;
                        default: key_pool[k] = $urandom;
                    endcase
            end
            roll = $urandom_range(0, 99);
            if (roll == 99)
                req.op = OP_UNUSED;
            else if (phase == 0)
                req.op = (roll < 60) ? op_code_t'($urandom_range(0, 1)) :
                         (roll < 90) ? OP_READ : op_code_t'($urandom_range(2, 5));
            else if (phase == 1)
                req.op = (roll < 60) ? op_code_t'($urandom_range(2, 5)) :
                         (roll < 80) ? OP_READ : op_code_t'($urandom_range(0, 1));
            else
                req.op = op_code_t'($urandom_range(0, 6));
            req.value    = ($urandom_range(0, 9) == 0) ? 32'($urandom) :
                           key_pool[$urandom_range(0, pool_size - 1)];
            req.position = 3'($urandom_range(0, 7));
            offer_request(req, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // wait out every result, then idle on to catch stray items
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: random idling per item, plus the long stall when asked.
    initial
    begin : receiver
        int      idle;
        result_t got;
        result_t want;
        forever
        begin
            idle = draw_idle(recv_calm);
            if (idle > 0 || sink_hold)
            begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge clk);
                while (sink_hold)
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.status     = status_t'(m_tdata[2:0]);
            got.new_count  = m_tdata[6:3];
            got.read_value = m_tdata[38:7];
            got.removed    = m_tdata[42:39];
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("ERROR: unexpected result item %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display({"ERROR: status %0d/%0d count %0d/%0d read %h/%h ",
                                  "removed %0d/%0d (exp/got)"},
                                 want.status, got.status, want.new_count, got.new_count,
                                 want.read_value, got.read_value, want.removed, got.removed);
                    mismatch_count++;
                end
            end
        end
    end

    // Hold off the receiver once for a long stretch so the input stalls.
    initial
    begin : long_stall
        int held;
        held = 0;
        while (accepted_items < HOLD_AFTER)
            @(posedge clk);
        sink_hold <= 1'b1;
        while (held < HOLD_CYCLES)
        begin
            @(posedge clk);
            held++;
        end
        sink_hold <= 1'b0;
    end

    // Watchdog: end the run as a failure once the cycle limit is reached.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== bounded_array_list.f =====
src/bal_pkg.sv
src/bal_datapath.sv
src/bal_ctrl.sv
src/bounded_array_list.sv
tb/sv/tb_bounded_array_list.sv
